FILE: sv/bor_pkg.sv
package bor_pkg;

    // Built depth of the record store
    localparam int DEPTH_DEF = 16;

    // Field widths fixed by the interface
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int ACT_W    = 4;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 3;
    localparam int CNT_OUT_W = 5;
    localparam int MAX_W    = 5;

    // Capacity register after reset
    localparam logic [MAX_W-1:0] MAX_RESET = 5'd16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 4'd2;
    localparam logic [ACT_W-1:0] ACT_INS_AT    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_RM_FRONT  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_RM_BACK   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_RM_AT     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_RM_KEY    = 4'd7;
    localparam logic [ACT_W-1:0] ACT_FIND      = 4'd8;
    localparam logic [ACT_W-1:0] ACT_READ_AT   = 4'd9;
    localparam logic [ACT_W-1:0] ACT_COUNT     = 4'd10;
    localparam logic [ACT_W-1:0] ACT_REVERSE   = 4'd11;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

FILE: sv/bounded_ordered_record_list_top.sv
// Ordered list of up to DEPTH key/value records held in one synchronous RAM
// (one write and one read per cycle, registered read data). One item is
// worked at a time and gives one result. Insert moves the records from the
// insert point on one place back; remove moves the later records one place
// forward; find, count value and remove by key scan the list, and remove by
// key then closes the gap; reverse swaps pairs from the two ends inward;
// read at reads one record. Clear, unknown and refused actions go straight
// to loading the result. Each shift or scan moves one record per cycle
// through the single RAM read port. A new item is taken while the last
// result still waits in the output register. No clearing pass after reset.
module bounded_ordered_record_list_top #(
    parameter int DEPTH = bor_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bor_pkg::MAX_W-1:0]      cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bor_pkg::ACT_W-1:0]      action,
    input  logic signed [bor_pkg::KEY_W-1:0] entry_key,
    input  logic [bor_pkg::VAL_W-1:0]      entry_value,
    input  logic [bor_pkg::POS_W-1:0]      position,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bor_pkg::STAT_W-1:0]     status,
    output logic signed [bor_pkg::KEY_W-1:0] found_key,
    output logic [bor_pkg::VAL_W-1:0]      found_value,
    output logic [bor_pkg::CNT_OUT_W-1:0]  match_count,
    output logic [bor_pkg::CNT_OUT_W-1:0]  size_now,
    output logic                           list_empty,
    output logic                           list_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = bor_pkg::KEY_W + bor_pkg::VAL_W;

    typedef logic [CW-1:0] cnt_t;
    typedef logic [RW-1:0] rec_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SHIFT_UP, S_SHIFT_DN, S_SCAN, S_READ, S_READ_WAIT,
        S_REV_A, S_REV_B, S_REV_C, S_REV_D, S_DONE
    } state_t;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    logic [bor_pkg::MAX_W-1:0] max_reg;
    logic [bor_pkg::ACT_W-1:0] act_reg, act_next;
    logic [bor_pkg::KEY_W-1:0] key_reg, key_next;
    logic [bor_pkg::VAL_W-1:0] val_reg, val_next;
    cnt_t   ins_reg, ins_next;
    cnt_t   idx_reg, idx_next;
    cnt_t   hi_reg, hi_next;
    logic   pend_reg, pend_next;
    cnt_t   pidx_reg, pidx_next;
    rec_t   tmp_reg, tmp_next;
    logic [bor_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [bor_pkg::KEY_W-1:0]  res_key_reg, res_key_next;
    logic [bor_pkg::VAL_W-1:0]  res_val_reg, res_val_next;
    cnt_t   res_cnt_reg, res_cnt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [bor_pkg::STAT_W-1:0]   status_reg, status_next;
    logic [bor_pkg::KEY_W-1:0]    fkey_reg, fkey_next;
    logic [bor_pkg::VAL_W-1:0]    fval_reg, fval_next;
    logic [bor_pkg::CNT_OUT_W-1:0] mcnt_reg, mcnt_next;
    logic [bor_pkg::CNT_OUT_W-1:0] size_reg, size_next;
    logic                         empty_reg, empty_next;
    logic                         full_reg, full_next;

    // Record store
    rec_t            mem [DEPTH];
    rec_t            rd_data_reg;
    logic            mem_re, mem_we;
    logic [AW-1:0]   rd_addr, wr_addr;
    rec_t            wr_data;

    // Clamp the capacity to 1..DEPTH
    cnt_t cap;
    logic [8:0] cnt9, pos9;
    logic is_full, is_empty;

    always_comb
    begin
        if (max_reg == '0)
            cap = cnt_t'(1);
        else if (9'(max_reg) > 9'(DEPTH))
            cap = cnt_t'(DEPTH);
        else
            cap = cnt_t'(max_reg);
    end

    assign cnt9     = 9'(cnt_reg);
    assign pos9     = 9'(position);
    assign is_full  = (cnt_reg >= cap);
    assign is_empty = (cnt_reg == '0);
    assign in_ready = (state_reg == S_IDLE);

    // Hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= bor_pkg::MAX_RESET;
        else if (cfg_we)
            max_reg <= cfg_wdata;
    end

    // Write and read the store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    // Sequence each item through the store
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        ins_next        = ins_reg;
        idx_next        = idx_reg;
        hi_next         = hi_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        tmp_next        = tmp_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_val_next    = res_val_reg;
        res_cnt_next    = res_cnt_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        fkey_next       = fkey_reg;
        fval_next       = fval_reg;
        mcnt_next       = mcnt_reg;
        size_next       = size_reg;
        empty_next      = empty_reg;
        full_next       = full_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = '0;
        wr_addr         = '0;
        wr_data         = '0;

        // Drop the result once transferred
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = action;
                    key_next        = entry_key;
                    val_next        = entry_value;
                    res_status_next = bor_pkg::ST_OK;
                    res_key_next    = '0;
                    res_val_next    = '0;
                    res_cnt_next    = '0;
                    pend_next       = 1'b0;
                    state_next      = S_DONE;
                    unique case (action) inside
                        bor_pkg::ACT_CLEAR:
                            cnt_next = '0;
                        bor_pkg::ACT_INS_FRONT, bor_pkg::ACT_INS_BACK:
                        begin
                            if (is_full)
                                res_status_next = bor_pkg::ST_FULL;
                            else
                            begin
                                ins_next   = (action == bor_pkg::ACT_INS_FRONT) ? '0 : cnt_reg;
                                idx_next   = cnt_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        bor_pkg::ACT_INS_AT:
                        begin
                            if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1)
                                res_status_next = bor_pkg::ST_BADPOS;
                            else if (is_full)
                                res_status_next = bor_pkg::ST_FULL;
                            else
                            begin
                                ins_next   = cnt_t'(pos9 - 9'd1);
                                idx_next   = cnt_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        bor_pkg::ACT_RM_FRONT, bor_pkg::ACT_RM_BACK:
                        begin
                            if (is_empty)
                                res_status_next = bor_pkg::ST_EMPTY;
                            else
                            begin
                                idx_next   = (action == bor_pkg::ACT_RM_FRONT) ? '0
                                                                              : cnt_reg - 1'b1;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        bor_pkg::ACT_RM_AT, bor_pkg::ACT_READ_AT:
                        begin
                            if (is_empty)
                                res_status_next = bor_pkg::ST_EMPTY;
                            else if (pos9 == 9'd0 || pos9 > cnt9)
                                res_status_next = bor_pkg::ST_BADPOS;
                            else
                            begin
                                idx_next   = cnt_t'(pos9 - 9'd1);
                                state_next = (action == bor_pkg::ACT_RM_AT) ? S_SHIFT_DN
                                                                           : S_READ;
                            end
                        end
                        bor_pkg::ACT_RM_KEY, bor_pkg::ACT_FIND:
                        begin
                            if (is_empty)
                                res_status_next = bor_pkg::ST_EMPTY;
                            else
                            begin
                                res_status_next = bor_pkg::ST_NOTFOUND;
                                idx_next        = '0;
                                state_next      = S_SCAN;
                            end
                        end
                        bor_pkg::ACT_COUNT:
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        bor_pkg::ACT_REVERSE:
                        begin
                            if (cnt9 > 9'd1)
                            begin
                                idx_next   = '0;
                                hi_next    = cnt_reg - 1'b1;
                                state_next = S_REV_A;
                            end
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            // Move records one place towards the back, then drop in the new one
            S_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    mem_we  = 1'b1;
                    wr_addr = AW'(pidx_reg + 1'b1);
                    wr_data = rd_data_reg;
                end
                if (idx_reg > ins_reg)
                begin
                    mem_re    = 1'b1;
                    rd_addr   = AW'(idx_reg - 1'b1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg - 1'b1;
                    idx_next  = idx_reg - 1'b1;
                end
                else if (!pend_reg)
                begin
                    mem_we     = 1'b1;
                    wr_addr    = AW'(ins_reg);
                    wr_data    = {key_reg, val_reg};
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                    pend_next = 1'b0;
            end

            // Close the gap by moving later records one place forward
            S_SHIFT_DN:
            begin
                if (pend_reg)
                begin
                    mem_we  = 1'b1;
                    wr_addr = AW'(pidx_reg - 1'b1);
                    wr_data = rd_data_reg;
                end
                if (9'(idx_reg) + 9'd1 < cnt9)
                begin
                    mem_re    = 1'b1;
                    rd_addr   = AW'(idx_reg + 1'b1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                    pend_next = 1'b0;
            end

            // Stream records past the key and value compare
            S_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    mem_re    = 1'b1;
                    rd_addr   = AW'(idx_reg);
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = S_DONE;
                end
                if (pend_reg)
                begin
                    case (act_reg)
                        bor_pkg::ACT_FIND:
                        begin
                            if (rd_data_reg[RW-1:bor_pkg::VAL_W] == key_reg)
                            begin
                                res_status_next = bor_pkg::ST_OK;
                                res_key_next    = rd_data_reg[RW-1:bor_pkg::VAL_W];
                                res_val_next    = rd_data_reg[bor_pkg::VAL_W-1:0];
                            end
                        end
                        bor_pkg::ACT_RM_KEY:
                        begin
                            if (rd_data_reg[RW-1:bor_pkg::VAL_W] == key_reg)
                            begin
                                res_status_next = bor_pkg::ST_OK;
                                mem_re          = 1'b0;
                                pend_next       = 1'b0;
                                idx_next        = pidx_reg;
                                state_next      = S_SHIFT_DN;
                            end
                        end
                        default:
                        begin
                            if (rd_data_reg[bor_pkg::VAL_W-1:0] == val_reg)
                                res_cnt_next = res_cnt_reg + 1'b1;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                mem_re     = 1'b1;
                rd_addr    = AW'(idx_reg);
                state_next = S_READ_WAIT;
            end

            S_READ_WAIT:
            begin
                res_key_next = rd_data_reg[RW-1:bor_pkg::VAL_W];
                res_val_next = rd_data_reg[bor_pkg::VAL_W-1:0];
                state_next   = S_DONE;
            end

            // Swap one pair from the two ends inward
            S_REV_A:
            begin
                mem_re     = 1'b1;
                rd_addr    = AW'(idx_reg);
                state_next = S_REV_B;
            end

            S_REV_B:
            begin
                mem_re     = 1'b1;
                rd_addr    = AW'(hi_reg);
                tmp_next   = rd_data_reg;
                state_next = S_REV_C;
            end

            S_REV_C:
            begin
                mem_we     = 1'b1;
                wr_addr    = AW'(idx_reg);
                wr_data    = rd_data_reg;
                state_next = S_REV_D;
            end

            S_REV_D:
            begin
                mem_we   = 1'b1;
                wr_addr  = AW'(hi_reg);
                wr_data  = tmp_reg;
                idx_next = idx_reg + 1'b1;
                hi_next  = hi_reg - 1'b1;
                if (9'(idx_reg) + 9'd2 < 9'(hi_reg))
                    state_next = S_REV_A;
                else
                    state_next = S_DONE;
            end

            // Load the result once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    fkey_next      = res_key_reg;
                    fval_next      = res_val_reg;
                    mcnt_next      = bor_pkg::CNT_OUT_W'(res_cnt_reg);
                    size_next      = bor_pkg::CNT_OUT_W'(cnt_reg);
                    empty_next     = is_empty;
                    full_next      = is_full;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            act_reg        <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            ins_reg        <= '0;
            idx_reg        <= '0;
            hi_reg         <= '0;
            pidx_reg       <= '0;
            tmp_reg        <= '0;
            res_status_reg <= bor_pkg::ST_OK;
            res_key_reg    <= '0;
            res_val_reg    <= '0;
            res_cnt_reg    <= '0;
            status_reg     <= bor_pkg::ST_OK;
            fkey_reg       <= '0;
            fval_reg       <= '0;
            mcnt_reg       <= '0;
            size_reg       <= '0;
            empty_reg      <= 1'b0;
            full_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            act_reg        <= act_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            ins_reg        <= ins_next;
            idx_reg        <= idx_next;
            hi_reg         <= hi_next;
            pidx_reg       <= pidx_next;
            tmp_reg        <= tmp_next;
            res_status_reg <= res_status_next;
            res_key_reg    <= res_key_next;
            res_val_reg    <= res_val_next;
            res_cnt_reg    <= res_cnt_next;
            status_reg     <= status_next;
            fkey_reg       <= fkey_next;
            fval_reg       <= fval_next;
            mcnt_reg       <= mcnt_next;
            size_reg       <= size_next;
            empty_reg      <= empty_next;
            full_reg       <= full_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_key   = fkey_reg;
    assign found_value = fval_reg;
    assign match_count = mcnt_reg;
    assign size_now    = size_reg;
    assign list_empty  = empty_reg;
    assign list_full   = full_reg;

    // Count never passes the built depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        9'(cnt_reg) <= 9'(DEPTH))
        else $error("record count beyond depth");

    // Read and write never meet on one entry in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (wr_addr != rd_addr))
        else $error("read and write to one entry");

    // Clear empties the list
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == bor_pkg::ACT_CLEAR) |=> (cnt_reg == '0))
        else $error("clear left records");

    // A result is loaded only from the finishing state
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside finish");

endmodule
